>>> sv/tlfk_pkg.sv
// Package for the two-link arm kinematics pipeline: widths, CORDIC arc table,
// register indexes and rounding helpers. No dependencies.
package tlfk_pkg;

  localparam int AngleBits  = 16;
  localparam int TrigStages = 16;
  localparam int CfgIdxW    = 1;

  localparam logic signed [31:0] CordicGain = 32'sd652032874;
  localparam logic signed [16:0] OneQ15     = 17'sd32767;

  typedef enum logic [CfgIdxW-1:0] {
    REG_UPPER_LENGTH = 1'b0,
    REG_LOWER_LENGTH = 1'b1
  } cfg_reg_e;

  function automatic logic [31:0] arc_step(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2F;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
      15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
      21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Map a raw 16-bit angle to the top of a 32-bit turn.
  function automatic logic [31:0] to_turn(input logic [15:0] raw);
    logic [AngleBits-1:0] a;
    logic [31:0] r;
    if (AngleBits >= 16) a = AngleBits'({raw} << (AngleBits - 16));
    else                 a = AngleBits'(raw >> (16 - AngleBits));
    r = 32'({a}) << (32 - AngleBits);
    return r;
  endfunction

  // Round half up, then clamp to the Q1.15 unit range.
  function automatic logic signed [15:0] rnd_clamp15(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767)       return 16'sd32767;
    else if (r < -34'sd32767) return -16'sd32767;
    else                      return r[15:0];
  endfunction

endpackage

>>> sv/tlfk_cordic.sv
// Pipelined CORDIC sin/cos, one stage per register, one angle per cycle.
// Uses tlfk_pkg for the arc table and rounding helper.
module tlfk_cordic
  import tlfk_pkg::*;
(
  input  logic               clk_i,
  input  logic [15:0]        angle_i,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  logic signed [33:0] x_q [TrigStages+1];
  logic signed [33:0] y_q [TrigStages+1];
  logic signed [32:0] z_q [TrigStages+1];
  logic               flip_q [TrigStages+1];

  logic [31:0] ang;
  logic [31:0] ang_f;
  logic        flip_d;

  always_comb begin
    ang    = to_turn(angle_i);
    flip_d = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    ang_f  = flip_d ? ang + 32'h80000000 : ang;
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= 34'(CordicGain);
    y_q[0]    <= '0;
    z_q[0]    <= 33'($signed(ang_f));
    flip_q[0] <= flip_d;
  end

  for (genvar i = 0; i < TrigStages; i++) begin : g_stage
    logic signed [33:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      if (!z_q[i][32]) begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - 33'(arc_step(i));
      end else begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + 33'(arc_step(i));
      end
    end
  end

  logic signed [33:0] xf, yf;
  assign xf = flip_q[TrigStages] ? -x_q[TrigStages] : x_q[TrigStages];
  assign yf = flip_q[TrigStages] ? -y_q[TrigStages] : y_q[TrigStages];

  always_ff @(posedge clk_i) begin
    cos_o <= rnd_clamp15(xf);
    sin_o <= rnd_clamp15(yf);
  end

endmodule

>>> sv/two_link_arm_forward_kinematics.sv
// Two-link arm forward kinematics. done_o is a delayed copy of an accepted start,
// aligned with the CORDIC chain and the stages that follow it.
// Throughput: one pose per cycle; results cannot be stalled.
// Reset clears the valid pipe and sets both link lengths to 1.0 (256 Q8.8).
// Depends on tlfk_pkg and tlfk_cordic.
module two_link_arm_forward_kinematics
  import tlfk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] azimuth_angle_i,
  input  logic signed [15:0] elevation_angle_i,
  input  logic signed [15:0] bend_angle_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [16:0] elbow_x_o,
  output logic signed [16:0] elbow_y_o,
  output logic signed [16:0] elbow_z_o,
  output logic signed [17:0] wrist_x_o,
  output logic signed [17:0] wrist_y_o,
  output logic signed [17:0] wrist_z_o
);

  localparam int TrigLat = TrigStages + 2;
  localparam int Lat     = TrigLat + 7;

  logic [15:0] upper_q, lower_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 16'd256;
      lower_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_UPPER_LENGTH: upper_q <= cfg_wdata_i;
        REG_LOWER_LENGTH: lower_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[Lat-2:0], start && !busy};
  end

  logic signed [15:0] sa, ca, se, ce, sb, cb;
  tlfk_cordic u_az (.clk_i, .angle_i(azimuth_angle_i),   .sin_o(sa), .cos_o(ca));
  tlfk_cordic u_el (.clk_i, .angle_i(elevation_angle_i), .sin_o(se), .cos_o(ce));
  tlfk_cordic u_bd (.clk_i, .angle_i(bend_angle_i),      .sin_o(sb), .cos_o(cb));

  // Stage A: direction d and axis k.
  logic signed [15:0] d0_a, d1_a, d2_a, k0_a, k1_a, sb_a;
  logic signed [16:0] omc_a;
  logic signed [31:0] p0, p1;
  assign p0 = ce * ca;
  assign p1 = ce * sa;
  always_ff @(posedge clk_i) begin
    d0_a  <= 16'((34'(p0) + 34'sd16384) >>> 15);
    d1_a  <= 16'((34'(p1) + 34'sd16384) >>> 15);
    d2_a  <= se;
    sb_a  <= sb;
    omc_a <= 17'sd32768 - 17'(cb);
    if (ce == 16'sd0) begin
      k0_a <= 16'sd32767; k1_a <= '0;
    end else if (!ce[15]) begin
      k0_a <= sa; k1_a <= -ca;
    end else begin
      k0_a <= -sa; k1_a <= ca;
    end
  end

  // Stage B: products for cross term and k.d.
  logic signed [15:0] d0_b, d1_b, d2_b, k0_b, k1_b, sb_b;
  logic signed [16:0] omc_b;
  logic signed [31:0] c0_b, c1_b, m0_b, m1_b;
  logic signed [31:0] k0d0_b, k1d1_b;
  always_ff @(posedge clk_i) begin
    d0_b <= d0_a; d1_b <= d1_a; d2_b <= d2_a;
    k0_b <= k0_a; k1_b <= k1_a; sb_b <= sb_a; omc_b <= omc_a;
    c0_b   <= k1_a * d2_a;
    c1_b   <= k0_a * d2_a;
    m0_b   <= k0_a * d1_a;
    m1_b   <= k1_a * d0_a;
    k0d0_b <= k0_a * d0_a;
    k1d1_b <= k1_a * d1_a;
  end

  // Stage C: cross product, k.d, t.
  logic signed [15:0] d_c [3];
  logic signed [15:0] sb_c;
  logic signed [16:0] omc_c;
  logic signed [32:0] cr_c [3];
  logic signed [16:0] kd;
  assign kd = 17'((34'(k0d0_b) + 34'(k1d1_b) + 34'sd16384) >>> 15);
  logic signed [33:0] t_c [3];
  always_ff @(posedge clk_i) begin
    d_c[0] <= d0_b; d_c[1] <= d1_b; d_c[2] <= d2_b;
    sb_c <= sb_b; omc_c <= omc_b;
    cr_c[0] <= 33'(c0_b);
    cr_c[1] <= -33'(c1_b);
    cr_c[2] <= 33'(m0_b) - 33'(m1_b);
    t_c[0] <= 34'(k0_b) * 34'(kd) - (34'(d0_b) <<< 15);
    t_c[1] <= 34'(k1_b) * 34'(kd) - (34'(d1_b) <<< 15);
    t_c[2] <= -(34'(d2_b) <<< 15);
  end

  // Stage D: Rodrigues products; stage E: sum and round; then lengths.
  logic signed [49:0] sc_d [3];
  logic signed [50:0] ot_d [3];
  logic signed [15:0] d_d [3];
  logic signed [15:0] df_e [3];
  logic signed [15:0] d_e [3];
  logic signed [32:0] el_f [3];
  logic signed [32:0] lw_f [3];
  logic signed [16:0] el_g [3];
  logic signed [17:0] wr_g [3];

  for (genvar j = 0; j < 3; j++) begin : g_ax
    logic signed [51:0] acc;
    logic signed [51:0] rs;
    assign acc = (52'(d_d[j]) <<< 30) + 52'(sc_d[j]) + 52'(ot_d[j]);
    assign rs  = (acc + (52'sd1 <<< 29)) >>> 30;
    always_ff @(posedge clk_i) begin
      sc_d[j] <= 50'(sb_c) * 50'(cr_c[j]);
      ot_d[j] <= 51'(omc_c) * 51'(t_c[j]);
      d_d[j]  <= d_c[j];
      d_e[j]  <= d_d[j];
      if (rs > 52'sd32767)       df_e[j] <= 16'sd32767;
      else if (rs < -52'sd32767) df_e[j] <= -16'sd32767;
      else                       df_e[j] <= rs[15:0];
      el_f[j] <= $signed({1'b0, upper_q}) * 33'(d_e[j]);
      lw_f[j] <= $signed({1'b0, lower_q}) * 33'(df_e[j]);
      el_g[j] <= 17'((el_f[j] + 33'sd16384) >>> 15);
      wr_g[j] <= 18'((el_f[j] + 33'sd16384) >>> 15) +
                 18'((lw_f[j] + 33'sd16384) >>> 15);
    end
  end

  assign done_o    = vld_q[Lat-1];
  assign elbow_x_o = el_g[0];
  assign elbow_y_o = el_g[1];
  assign elbow_z_o = el_g[2];
  assign wrist_x_o = wr_g[0];
  assign wrist_y_o = wr_g[1];
  assign wrist_z_o = wr_g[2];

  // Every accepted word must come back on done_o.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o) else $error("lost word");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[Lat-2])) else $error("spurious word");
  a_vertical_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ce == 16'sd0) |=> (k0_a == 16'sd32767 && k1_a == 16'sd0))
    else $error("axis fallback");

endmodule

>>> bench/tb_two_link_arm_forward_kinematics.sv
// Testbench for two_link_arm_forward_kinematics: directed and random poses under
// several link-length settings, checked against an in-bench fixed-point predictor.
// Depends on tlfk_pkg and the block's RTL.
module tb_two_link_arm_forward_kinematics;
  import tlfk_pkg::*;

  typedef struct packed {
    logic [2:0][16:0] elbow;
    logic [2:0][17:0] wrist;
  } arm_pose_t;

  class pose_scoreboard;
    arm_pose_t pending[$];
    int unsigned upper_len = 256;
    int unsigned lower_len = 256;
    int errors = 0;
    int checked = 0;
    longint arcs[16] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                         32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                         32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                         32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

    function longint rnd(input longint v, input int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint unit_clamp(input longint v);
      if (v > 32767) return 32767;
      if (v < -32767) return -32767;
      return v;
    endfunction

    function void sin_cos(input logic [15:0] raw, output longint s, output longint c);
      logic [31:0] ang;
      bit flip;
      longint x, y, z, xs, ys;
      ang = {raw, 16'h0000};
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang = ang + 32'h80000000;
      z = longint'($signed(ang));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - arcs[i];
        end else begin
          x = x + ys; y = y - xs; z = z + arcs[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = unit_clamp(rnd(x, 15));
      s = unit_clamp(rnd(y, 15));
    endfunction

    function void note_pose(input logic [15:0] az, input logic [15:0] ev,
                            input logic [15:0] bd);
      longint sa, ca, se, ce, sb, cb, kd, omc, acc, df, el, wr;
      longint d[3], k[3], cr[3], tt[3];
      arm_pose_t p;
      sin_cos(az, sa, ca);
      sin_cos(ev, se, ce);
      sin_cos(bd, sb, cb);
      d[0] = rnd(ce * ca, 15);
      d[1] = rnd(ce * sa, 15);
      d[2] = se;
      // vertical arm: fall back to x axis
      if (ce == 0) begin
        k[0] = 32767; k[1] = 0; k[2] = 0;
      end else if (ce > 0) begin
        k[0] = sa; k[1] = -ca; k[2] = 0;
      end else begin
        k[0] = -sa; k[1] = ca; k[2] = 0;
      end
      cr[0] = k[1] * d[2] - k[2] * d[1];
      cr[1] = k[2] * d[0] - k[0] * d[2];
      cr[2] = k[0] * d[1] - k[1] * d[0];
      kd = rnd(k[0] * d[0] + k[1] * d[1] + k[2] * d[2], 15);
      omc = 32768 - cb;
      for (int j = 0; j < 3; j++) begin
        tt[j] = k[j] * kd - d[j] * 32768;
        acc = d[j] * (64'sd1 <<< 30) + sb * cr[j] + omc * tt[j];
        df = unit_clamp(rnd(acc, 30));
        el = rnd(longint'(upper_len) * d[j], 15);
        wr = el + rnd(longint'(lower_len) * df, 15);
        p.elbow[j] = el[16:0];
        p.wrist[j] = wr[17:0];
      end
      pending.push_back(p);
    endfunction

    function void check_pose(input arm_pose_t got);
      arm_pose_t exp_p;
      string axis[3] = '{"x", "y", "z"};
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, elbow %h wrist %h", $time, got.elbow, got.wrist);
        errors++;
        return;
      end
      exp_p = pending.pop_front();
      checked++;
      for (int j = 0; j < 3; j++) begin
        if (exp_p.elbow[j] !== got.elbow[j]) begin
          $display("%0t: elbow_%s expected %h actual %h", $time, axis[j],
                   exp_p.elbow[j], got.elbow[j]);
          errors++;
        end
        if (exp_p.wrist[j] !== got.wrist[j]) begin
          $display("%0t: wrist_%s expected %h actual %h", $time, axis[j],
                   exp_p.wrist[j], got.wrist[j]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] azimuth_angle_i = '0;
  logic signed [15:0] elevation_angle_i = '0;
  logic signed [15:0] bend_angle_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = REG_UPPER_LENGTH;
  logic [15:0] cfg_wdata_i = '0;
  logic done_o;
  logic signed [16:0] elbow_x_o, elbow_y_o, elbow_z_o;
  logic signed [17:0] wrist_x_o, wrist_y_o, wrist_z_o;

  pose_scoreboard sb = new();
  int gap_mode = 1;
  int poses_sent = 0;

  two_link_arm_forward_kinematics dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    arm_pose_t got;
    if (rst_ni && done_o) begin
      got.elbow = {elbow_z_o, elbow_y_o, elbow_x_o};
      got.wrist = {wrist_z_o, wrist_y_o, wrist_x_o};
      sb.check_pose(got);
    end
  end

  // Call at a falling edge; returns at a falling edge.
  task automatic idle_gap();
    int n;
    n = 0;
    if (gap_mode != 0) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: n = $urandom_range(1, 3);
        4: n = $urandom_range(15, 60);
        default: n = 0;
      endcase
    end
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_pose(input logic [15:0] az, input logic [15:0] ev,
                           input logic [15:0] bd);
    bit taken;
    idle_gap();
    azimuth_angle_i = az;
    elevation_angle_i = ev;
    bend_angle_i = bd;
    start = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
      if (taken) sb.note_pose(az, ev, bd);
      @(negedge clk_i);
    end
    poses_sent++;
  endtask

  // Drop start and hold until every expected word has come back.
  task automatic drain();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    if (idx == REG_UPPER_LENGTH) sb.upper_len = val;
    else sb.lower_len = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_poses(input int count);
    logic [15:0] ev;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: ev = 16'h4000 + 16'($urandom_range(0, 8)) - 16'd4;
        1: ev = 16'hC000 + 16'($urandom_range(0, 8)) - 16'd4;
        default: ev = 16'($urandom);
      endcase
      send_pose(16'($urandom), ev, 16'($urandom));
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    logic [15:0] corners[6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000,
                                16'hC000};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset lengths, extreme angles, vertical arm and folded elbow
    gap_mode = 0;
    for (int i = 0; i < 6; i++) send_pose(corners[i], corners[5 - i], corners[i]);
    send_pose(16'h1234, 16'h4000, 16'h2000);
    send_pose(16'h1234, 16'hC000, 16'hE000);
    send_pose(16'h0000, 16'h3FFF, 16'h8000);
    send_pose(16'h2000, 16'h4001, 16'h4000);
    send_pose(16'hA000, 16'h6000, 16'h8000);
    send_pose(16'h5555, 16'hAAAA, 16'h7FFF);
    send_pose(16'h0000, 16'h0000, 16'h0000);
    send_pose(16'h4000, 16'h2000, 16'hC000);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_UPPER_LENGTH, 16'h0000); write_reg(REG_LOWER_LENGTH, 16'h0000); end
        1: begin write_reg(REG_UPPER_LENGTH, 16'hFFFF); write_reg(REG_LOWER_LENGTH, 16'hFFFF); end
        2: begin write_reg(REG_UPPER_LENGTH, 16'hFFFF); write_reg(REG_LOWER_LENGTH, 16'h0000); end
        3: begin
          write_reg(REG_UPPER_LENGTH, 16'($urandom));
          write_reg(REG_LOWER_LENGTH, 16'($urandom));
        end
        default: begin write_reg(REG_UPPER_LENGTH, 16'h0100); write_reg(REG_LOWER_LENGTH, 16'h0100); end
      endcase
      gap_mode = (ph != 2);
      if (ph == 0) for (int i = 0; i < 6; i++) send_pose(corners[i], corners[i], corners[5 - i]);
      random_poses(260);
      drain();
    end

    start = 1'b0;
    $display("sent %0d poses over six link-length settings, %0d results checked",
             poses_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
sv/tlfk_pkg.sv
sv/tlfk_cordic.sv
sv/two_link_arm_forward_kinematics.sv
bench/tb_two_link_arm_forward_kinematics.sv
